// ----- rtl/core/lzw_pkg.sv -----
// shared types and constants for the lz77 window copy block
package lzw_pkg;

  localparam int BYTE_W = 8;
  localparam int DIST_W = 22;
  localparam int CODE_W = 8;
  localparam int LEN_W  = 9;
  localparam int CNT_W  = 4;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 2;
  localparam int IDX_W  = 2;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEW     = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_LEN2_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_LEN3_LIMIT = 2'd1;

  localparam logic [DIST_W-1:0] LEN2_LIMIT_RESET = 22'd255;
  localparam logic [DIST_W-1:0] LEN3_LIMIT_RESET = 22'd8191;

  // control states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  // request to the recent distance ring
  typedef struct packed {
    logic              new_en;
    logic              rep_en;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] new_dist;
  } ring_req_t;

endpackage

// ----- rtl/core/lzw_if.sv -----
// channel interfaces for tokens, output beats and configuration
interface lzw_tok_if;
  logic                              valid;
  logic                              ready;
  logic [lzw_pkg::KIND_W-1:0]        token_kind;
  logic [lzw_pkg::BYTE_W-1:0]        literal_byte;
  logic [lzw_pkg::SLOT_W-1:0]        repeat_slot;
  logic [lzw_pkg::DIST_W-1:0]        match_distance;
  logic [lzw_pkg::CODE_W-1:0]        length_code;
  modport source (output valid, token_kind, literal_byte, repeat_slot, match_distance,
                  length_code, input ready);
  modport sink   (input valid, token_kind, literal_byte, repeat_slot, match_distance,
                  length_code, output ready);
endinterface

interface lzw_beat_if #(parameter int BEAT_BYTES = 8);
  logic                         valid;
  logic                         ready;
  logic [8*BEAT_BYTES-1:0]      out_bytes;
  logic [lzw_pkg::CNT_W-1:0]    byte_count;
  logic                         last_beat;
  modport source (output valid, out_bytes, byte_count, last_beat, input ready);
  modport sink   (input valid, out_bytes, byte_count, last_beat, output ready);
endinterface

interface lzw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lzw_pkg::IDX_W-1:0]   index;
  logic [lzw_pkg::DIST_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lzw_hist_mem.sv -----
// history window memory, one write and one registered read port
module lzw_hist_mem #(
  parameter int AW = 16
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lzw_pkg::BYTE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lzw_pkg::BYTE_W-1:0]  rd_data
);

  logic [lzw_pkg::BYTE_W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/lzw_ring.sv -----
// four-entry recent distance ring with move-to-front on reuse
module lzw_ring (
  input  logic                        clk,
  input  logic                        rst,
  input  lzw_pkg::ring_req_t          req,
  output logic [lzw_pkg::DIST_W-1:0]  rd_dist
);

  logic [lzw_pkg::DIST_W-1:0] ring [4];
  logic [1:0]                 ptr;
  logic [1:0]                 ptr_next;
  logic [1:0]                 sel;

  // entry picked for a repeat, or the new distance
  assign sel      = ptr - req.slot;
  assign ptr_next = ptr + 2'd1;
  assign rd_dist  = req.new_en ? req.new_dist : ring[sel];

  // pointer update
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= 2'd0;
    end else if (req.new_en) begin
      ptr <= ptr_next;
    end
  end

  // entries: push, or age the younger ones and put the reused one in front
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        ring[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        logic [1:0] age;
        age = ptr - 2'(i);
        if (req.new_en) begin
          if (2'(i) == ptr_next) begin
            ring[i] <= req.new_dist;
          end
        end else if (req.rep_en) begin
          if (age == 2'd0) begin
            ring[i] <= ring[sel];
          end else if (age <= req.slot) begin
            ring[i] <= ring[2'(i + 1)];
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/lz77_window_copy_with_recent_dists.sv -----
// top level: token control, copy engine, beat packer and configuration
// Decodes literal and match tokens into a 2^WINDOW_BITS byte history window and
// streams the rebuilt bytes in beats of up to BEAT_BYTES. After reset the window
// is cleared one byte a cycle, during which no token is taken; configuration
// writes are taken at all times. One token is worked on at a time. The copy
// moves one byte a cycle while the output is not stalled, through the one read
// and one write port of the window memory. Beats leave through an output
// register; a beat that is not taken stalls the copy once the next beat is
// complete.
module lz77_window_copy_with_recent_dists #(
  parameter int WINDOW_BITS = 16,
  parameter int BEAT_BYTES  = 8
) (
  input  logic          clk,
  input  logic          rst,
  lzw_cfg_if.sink       cfg,
  lzw_tok_if.sink       tokens,
  lzw_beat_if.source    beats
);

  localparam int AW = WINDOW_BITS;
  localparam int BW = 8 * BEAT_BYTES;

  logic [1:0]                     state;
  logic [lzw_pkg::DIST_W-1:0]     len2_limit;
  logic [lzw_pkg::DIST_W-1:0]     len3_limit;
  logic [AW-1:0]                  wp;
  logic [AW-1:0]                  src;
  logic [AW-1:0]                  clr_addr;
  logic [lzw_pkg::LEN_W-1:0]      rd_left;
  logic [lzw_pkg::LEN_W-1:0]      left;
  logic                           pend;
  logic                           fwd;
  logic [lzw_pkg::BYTE_W-1:0]     fwd_data;
  logic [lzw_pkg::BYTE_W-1:0]     q;
  logic [lzw_pkg::BYTE_W-1:0]     cur_byte;
  logic [BW-1:0]                  acc;
  logic [BW-1:0]                  acc_next;
  logic [lzw_pkg::CNT_W-1:0]      fill;
  logic                           oval;
  logic [BW-1:0]                  odata;
  logic [lzw_pkg::CNT_W-1:0]      ocnt;
  logic                           olast;
  logic                           out_free;
  logic                           is_last;
  logic                           completes;
  logic                           consume;
  logic                           issue;
  logic                           tok_acc;
  lzw_pkg::ring_req_t             rreq;
  logic [lzw_pkg::DIST_W-1:0]     tok_dist;
  logic [lzw_pkg::LEN_W-1:0]      len;
  logic [lzw_pkg::LEN_W-1:0]      base;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [lzw_pkg::BYTE_W-1:0]     mem_wdata;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      len2_limit <= lzw_pkg::LEN2_LIMIT_RESET;
      len3_limit <= lzw_pkg::LEN3_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        lzw_pkg::REG_LEN2_LIMIT: len2_limit <= cfg.data;
        lzw_pkg::REG_LEN3_LIMIT: len3_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // token acceptance and ring request
  assign tokens.ready  = (state == lzw_pkg::ST_IDLE);
  assign tok_acc       = tokens.valid && tokens.ready;
  assign rreq.new_en   = tok_acc && (tokens.token_kind == lzw_pkg::KIND_NEW);
  assign rreq.rep_en   = tok_acc && (tokens.token_kind == lzw_pkg::KIND_REPEAT);
  assign rreq.slot     = tokens.repeat_slot;
  assign rreq.new_dist = tokens.match_distance;

  lzw_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (rreq),
    .rd_dist (tok_dist)
  );

  // match length
  always_comb begin
    if (tokens.token_kind == lzw_pkg::KIND_NEW) begin
      base = lzw_pkg::LEN_W'(2);
      if (tok_dist > len2_limit) begin
        base = (tok_dist > len3_limit) ? lzw_pkg::LEN_W'(4) : lzw_pkg::LEN_W'(3);
      end
    end else begin
      base = (tokens.repeat_slot > 2'd1) ? lzw_pkg::LEN_W'(3) : lzw_pkg::LEN_W'(2);
    end
    len = base + lzw_pkg::LEN_W'(tokens.length_code);
  end

  // copy engine handshake between read stage and write stage
  assign cur_byte  = fwd ? fwd_data : q;
  assign out_free  = !oval || beats.ready;
  assign is_last   = (left == lzw_pkg::LEN_W'(1));
  assign completes = is_last || (fill == lzw_pkg::CNT_W'(BEAT_BYTES - 1));
  assign consume   = (state == lzw_pkg::ST_RUN) && pend && (!completes || out_free);
  assign issue     = (state == lzw_pkg::ST_RUN) && (rd_left != '0) && (!pend || consume);

  // memory write port: clearing pass or copy write
  always_comb begin
    if (state == lzw_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = consume;
      mem_waddr = wp;
      mem_wdata = cur_byte;
    end
  end

  lzw_hist_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (issue),
    .rd_addr (src),
    .rd_data (q)
  );

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lzw_pkg::ST_CLEAR;
      clr_addr <= '0;
      wp       <= '0;
      rd_left  <= '0;
      left     <= '0;
      pend     <= 1'b0;
    end else begin
      case (state)
        lzw_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= lzw_pkg::ST_IDLE;
          end
        end
        lzw_pkg::ST_IDLE: begin
          if (tok_acc) begin
            if (tokens.token_kind == lzw_pkg::KIND_LITERAL) begin
              state   <= lzw_pkg::ST_RUN;
              pend    <= 1'b1;
              rd_left <= '0;
              left    <= lzw_pkg::LEN_W'(1);
            end else if (rreq.new_en || rreq.rep_en) begin
              state   <= lzw_pkg::ST_RUN;
              src     <= wp - AW'(tok_dist) - AW'(1);
              rd_left <= len;
              left    <= len;
            end
          end
        end
        lzw_pkg::ST_RUN: begin
          if (issue) begin
            src     <= src + 1'b1;
            rd_left <= rd_left - 1'b1;
            pend    <= 1'b1;
          end else if (consume) begin
            pend <= 1'b0;
          end
          if (consume) begin
            wp   <= wp + 1'b1;
            left <= left - 1'b1;
          end
          if (left == '0) begin
            state <= lzw_pkg::ST_IDLE;
          end
        end
        default: state <= lzw_pkg::ST_IDLE;
      endcase
    end
  end

  // forwarding of a byte written in the same cycle as its read
  always_ff @(posedge clk) begin
    if (tok_acc && (tokens.token_kind == lzw_pkg::KIND_LITERAL)) begin
      fwd      <= 1'b1;
      fwd_data <= tokens.literal_byte;
    end else if (issue) begin
      fwd      <= consume && (wp == src);
      fwd_data <= cur_byte;
    end
  end

  // beat packing
  always_comb begin
    acc_next = acc;
    acc_next[fill*8 +: 8] = cur_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      acc  <= '0;
      oval <= 1'b0;
    end else begin
      if (beats.ready) begin
        oval <= 1'b0;
      end
      if (consume) begin
        if (completes) begin
          oval  <= 1'b1;
          odata <= acc_next;
          ocnt  <= fill + 1'b1;
          olast <= is_last;
          fill  <= '0;
          acc   <= '0;
        end else begin
          fill <= fill + 1'b1;
          acc  <= acc_next;
        end
      end
    end
  end

  assign beats.valid      = oval;
  assign beats.out_bytes  = odata;
  assign beats.byte_count = ocnt;
  assign beats.last_beat  = olast;

endmodule

// ----- bench/lz77_window_copy_with_recent_dists_tb.sv -----
// testbench for the lz77 window copy block with recent distance ring
`timescale 1ns / 1ps
module lz77_window_copy_with_recent_dists_tb;

  localparam int WBITS = 16;
  localparam int WSIZE = 1 << WBITS;
  localparam int IDLE_LIMIT = 200000;

  // token kind and register index outside the defined sets
  localparam logic [lzw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [lzw_pkg::IDX_W-1:0]  REG_UNUSED  = 2'd3;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzw_cfg_if  cfg ();
  lzw_tok_if  tokens ();
  lzw_beat_if #(.BEAT_BYTES(8)) beats ();

  lz77_window_copy_with_recent_dists #(.WINDOW_BITS(WBITS), .BEAT_BYTES(8)) uut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .tokens(tokens.sink), .beats(beats.source)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [7:0]                 hist [WSIZE];
  logic [WBITS-1:0]           wptr;
  logic [lzw_pkg::DIST_W-1:0] ring [4];
  logic [1:0]                 rptr;
  logic [lzw_pkg::DIST_W-1:0] lim2, lim3;
  beat_t                      pending_beats [$];

  int mismatches = 0;
  int idle_cycles = 0;
  logic [63:0] acc;
  int fill;

  // push one byte into the window and the beat being built
  task automatic put_byte(input logic [7:0] b, input bit last);
    hist[wptr] = b;
    wptr = wptr + 1'b1;
    acc |= 64'(b) << (8 * fill);
    fill++;
    if (fill == 8 || last) begin
      pending_beats.push_back({acc, 4'(fill), last});
      acc = '0;
      fill = 0;
    end
  endtask

  // expected beats for one token
  task automatic predict_token(input logic [1:0] kind, input logic [7:0] lit,
                               input logic [1:0] slot,
                               input logic [lzw_pkg::DIST_W-1:0] nd,
                               input logic [7:0] code);
    logic [lzw_pkg::DIST_W-1:0] d;
    int len;
    logic [WBITS-1:0] src;
    acc = '0;
    fill = 0;
    if (kind == lzw_pkg::KIND_LITERAL) begin
      put_byte(lit, 1'b1);
      return;
    end
    if (kind != lzw_pkg::KIND_NEW && kind != lzw_pkg::KIND_REPEAT) return;
    if (kind == lzw_pkg::KIND_NEW) begin
      d = nd;
      rptr = rptr + 1'b1;
      ring[rptr] = d;
      len = 2;
      if (d > lim2) begin
        len++;
        if (d > lim3) len++;
      end
    end else begin
      d = ring[rptr - slot];
      for (int a = slot; a > 0; a--) ring[2'(rptr - a)] = ring[2'(rptr - a + 1)];
      ring[rptr] = d;
      len = (slot > 1) ? 3 : 2;
    end
    len += code;
    src = wptr - WBITS'(d + 1);
    for (int k = 0; k < len; k++) begin
      put_byte(hist[src], k + 1 == len);
      src = src + 1'b1;
    end
  endtask

  // drive one token transaction
  task automatic send_token(input logic [1:0] kind, input logic [7:0] lit,
                            input logic [1:0] slot,
                            input logic [lzw_pkg::DIST_W-1:0] nd,
                            input logic [7:0] code);
    repeat ($urandom_range(0, 5)) @(posedge clk);
    tokens.valid <= 1'b1;
    tokens.token_kind <= kind;
    tokens.literal_byte <= lit;
    tokens.repeat_slot <= slot;
    tokens.match_distance <= nd;
    tokens.length_code <= code;
    do @(posedge clk); while (!tokens.ready);
    predict_token(kind, lit, slot, nd, code);
    tokens.valid <= 1'b0;
    @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [lzw_pkg::IDX_W-1:0] idx,
                           input logic [lzw_pkg::DIST_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == lzw_pkg::REG_LEN2_LIMIT) lim2 = val;
    else if (idx == lzw_pkg::REG_LEN3_LIMIT) lim3 = val;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random output stall per beat
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      beats.ready <= 1'b0;
    end else if (beats.valid && beats.ready) begin
      stall_left = $urandom_range(0, 5);
      beats.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      beats.ready <= (stall_left == 0);
    end else begin
      beats.ready <= 1'b1;
    end
  end

  // compare each beat transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && beats.valid && beats.ready) begin
      beat_t got, want;
      got = {beats.out_bytes, beats.byte_count, beats.last_beat};
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: exp data %h cnt %0d last %0b, got data %h cnt %0d last %0b",
                     want.data, want.count, want.last, got.data, got.count, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((tokens.valid && tokens.ready) || (beats.valid && beats.ready) ||
        (cfg.valid && cfg.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT + WSIZE) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed;
    send_token(lzw_pkg::KIND_LITERAL, 8'h00, 2'd3, '1, 8'hFF);
    send_token(lzw_pkg::KIND_LITERAL, 8'hFF, 2'd0, '0, 8'h00);
    send_token(lzw_pkg::KIND_LITERAL, 8'hA5, 2'd1, 22'h155555, 8'h5A);
    send_token(lzw_pkg::KIND_NEW, 8'hFF, 2'd3, 22'd0, 8'd0);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, 22'd2, 8'd255);
    send_token(lzw_pkg::KIND_NEW, 8'h11, 2'd2, 22'd256, 8'd3);
    send_token(lzw_pkg::KIND_NEW, 8'h22, 2'd1, 22'd8192, 8'd6);
    send_token(lzw_pkg::KIND_NEW, 8'h33, 2'd0, '1, 8'd9);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, 22'd255, 8'd1);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, 22'd8191, 8'd1);
    for (int s = 0; s < 4; s++)
      send_token(lzw_pkg::KIND_REPEAT, 8'hFF, 2'(s), '1, 8'(s * 5));
    send_token(KIND_UNUSED, 8'h77, 2'd2, 22'd5, 8'd9);
    send_token(lzw_pkg::KIND_REPEAT, 8'h00, 2'd3, '0, 8'd255);
    drain();
  endtask

  task automatic test_limits;
    write_reg(lzw_pkg::REG_LEN2_LIMIT, 22'd0);
    write_reg(lzw_pkg::REG_LEN3_LIMIT, '1);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, 22'd0, 8'd1);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, 22'd1, 8'd1);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, '1, 8'd1);
    drain();
    write_reg(lzw_pkg::REG_LEN2_LIMIT, '1);
    write_reg(lzw_pkg::REG_LEN3_LIMIT, 22'd0);
    write_reg(REG_UNUSED, 22'd17);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, 22'd100, 8'd2);
    send_token(lzw_pkg::KIND_NEW, 8'h00, 2'd0, '1, 8'd2);
    drain();
  endtask

  task automatic test_random(input int n);
    logic [1:0] k;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = r < 40 ? lzw_pkg::KIND_LITERAL : r < 70 ? lzw_pkg::KIND_NEW :
          r < 97 ? lzw_pkg::KIND_REPEAT : KIND_UNUSED;
      send_token(k, 8'($urandom), 2'($urandom),
                 ($urandom_range(0, 9) == 0) ? 22'($urandom) : 22'($urandom_range(0, 40)),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)));
    end
    drain();
  endtask

  initial begin
    foreach (hist[i]) hist[i] = 8'h00;
    foreach (ring[i]) ring[i] = '0;
    wptr = '0;
    rptr = '0;
    lim2 = lzw_pkg::LEN2_LIMIT_RESET;
    lim3 = lzw_pkg::LEN3_LIMIT_RESET;
    tokens.valid = 1'b0;
    tokens.token_kind = '0;
    tokens.literal_byte = '0;
    tokens.repeat_slot = '0;
    tokens.match_distance = '0;
    tokens.length_code = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_limits();
    write_reg(lzw_pkg::REG_LEN2_LIMIT, 22'd10);
    write_reg(lzw_pkg::REG_LEN3_LIMIT, 22'd25);
    test_random(160);
    write_reg(lzw_pkg::REG_LEN2_LIMIT, lzw_pkg::LEN2_LIMIT_RESET);
    write_reg(lzw_pkg::REG_LEN3_LIMIT, lzw_pkg::LEN3_LIMIT_RESET);
    test_random(140);
    if (mismatches == 0 && pending_beats.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lzw_pkg.sv
rtl/core/lzw_if.sv
rtl/core/lzw_hist_mem.sv
rtl/core/lzw_ring.sv
rtl/core/lz77_window_copy_with_recent_dists.sv
bench/lz77_window_copy_with_recent_dists_tb.sv
